/* rtl/core/dm_pkg.sv */
// ----------------------------------------------------------------------------
// dm_pkg: shared definitions for the mono downmix block
// Widths, the frame record handed from the accumulator to the divider,
// queue status, and the divider state encoding.
// ----------------------------------------------------------------------------
package dm_pkg;

  // Block sizing.
  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 32;

  // Fixed field widths.
  localparam int DATA_W = 32;
  localparam int CFG_W  = 4;

  // Derived widths.
  localparam int IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_CHANNELS) + 1;
  localparam int STEP_W = $clog2(SUM_W);

  // Frame queue depth.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One finished frame: exact sum and count of nonzero samples.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } dm_frame_t;

  // Push request from the accumulator into the queue.
  typedef struct packed {
    logic      valid;
    dm_frame_t frame;
  } dm_push_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } dm_qstat_t;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DM_IDLE,
    DM_DIVIDE,
    DM_DONE
  } dm_state_t;

endpackage

/* rtl/core/dm_if.sv */
// ----------------------------------------------------------------------------
// dm_if: stream channels of the mono downmix block
// Valid/ready channels for the interleaved input samples and the mono output.
// ----------------------------------------------------------------------------
interface dm_sample_if;
  import dm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface dm_mono_if;
  import dm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] mono_sample;

  modport source (output valid, output mono_sample, input ready);
  modport sink (input valid, input mono_sample, output ready);
endinterface

/* rtl/core/dm_front.sv */
// ----------------------------------------------------------------------------
// dm_front: frame accumulator
// Accepts one sample per cycle (a frame end stalls while the queue is full),
// tracks channel position, exact sum and nonzero count, queues each frame.
// ----------------------------------------------------------------------------
module dm_front
  import dm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  dm_sample_if.sink        sample_in,
  input  dm_qstat_t        qstat,
  output dm_push_t         push
);

  logic [CFG_W-1:0]        channel_count;
  logic [IDX_W-1:0]        channel_index;
  logic signed [SUM_W-1:0] frame_sum;
  logic [CNT_W-1:0]        nonzero_count;

  logic [CNT_W:0]          cfg_ext;
  logic [CNT_W:0]          chans;
  logic [CNT_W:0]          pos_next;
  logic                    frame_end;
  logic                    accept;
  logic signed [SUM_W-1:0] sample_ext;
  logic signed [SUM_W-1:0] frame_sum_next;
  logic [CNT_W-1:0]        nonzero_count_next;

  // Clamp the configured channel count to the supported range.
  always_comb begin
    cfg_ext = (CNT_W + 1)'(channel_count);
    if (cfg_ext == '0) begin
      chans = (CNT_W + 1)'(1);
    end else if (cfg_ext > (CNT_W + 1)'(MAX_CHANNELS)) begin
      chans = (CNT_W + 1)'(MAX_CHANNELS);
    end else begin
      chans = cfg_ext;
    end
  end

  // The frame ends when this item reaches the channel count.
  assign pos_next  = (CNT_W + 1)'(channel_index) + (CNT_W + 1)'(1);
  assign frame_end = (pos_next >= chans);

  // Only a frame-ending item needs room in the queue.
  assign sample_in.ready = !frame_end || !qstat.full;
  assign accept          = sample_in.valid && sample_in.ready;

  // Sign-extend the active sample bits and accumulate.
  assign sample_ext         = SUM_W'(signed'(sample_in.sample[SAMPLE_BITS-1:0]));
  assign frame_sum_next     = frame_sum + sample_ext;
  assign nonzero_count_next = nonzero_count + CNT_W'(sample_ext != '0);

  assign push.valid       = accept && frame_end;
  assign push.frame.sum   = frame_sum_next;
  assign push.frame.count = nonzero_count_next;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CFG_W'(2);
    end else if (cfg_we) begin
      channel_count <= cfg_wdata;
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= '0;
      frame_sum     <= '0;
      nonzero_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        channel_index <= '0;
        frame_sum     <= '0;
        nonzero_count <= '0;
      end else begin
        channel_index <= IDX_W'(pos_next);
        frame_sum     <= frame_sum_next;
        nonzero_count <= nonzero_count_next;
      end
    end
  end

endmodule

/* rtl/core/dm_queue.sv */
// ----------------------------------------------------------------------------
// dm_queue: frame queue
// Short register FIFO that decouples the accumulator from the divider.
// ----------------------------------------------------------------------------
module dm_queue
  import dm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dm_push_t  push,
  input  logic      pop,
  output dm_frame_t head,
  output dm_qstat_t qstat
);

  dm_frame_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  logic do_push;
  logic do_pop;

  assign qstat.full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.frame;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  // A push is never offered to a full queue.
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !qstat.full)
    else $error("dm_queue: push while full");

  // The fill level never exceeds the depth.
  assert property (@(posedge clk) disable iff (rst) fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("dm_queue: fill level out of range");

  // The fill level tracks pushes and pops.
  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + QCNT_W'(1)))
    else $error("dm_queue: fill did not follow a push");

endmodule

/* rtl/core/dm_back.sv */
// ----------------------------------------------------------------------------
// dm_back: frame divider
// Takes frames from the queue, divides the sum by the nonzero count one
// quotient bit per cycle, and holds the mono result in an output register.
// ----------------------------------------------------------------------------
module dm_back
  import dm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dm_frame_t head,
  input  dm_qstat_t qstat,
  output logic      pop,
  dm_mono_if.source mono_out
);

  dm_state_t state;
  dm_state_t state_next;

  logic [STEP_W-1:0]       step;
  logic [SUM_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic [CNT_W-1:0]        divisor;
  logic                    neg;
  logic                    out_valid;
  logic signed [DATA_W-1:0] out_data;

  logic [CNT_W:0]          rem_shift;
  logic                    fits;
  logic [CNT_W-1:0]        rem_next;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        quo_signed;
  logic signed [DATA_W-1:0] result;
  logic                    out_free;
  logic                    load_out;
  logic                    last_step;

  assign out_free  = !out_valid || mono_out.ready;
  assign last_step = (step == STEP_W'(SUM_W - 1));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      DM_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          state_next = DM_DIVIDE;
        end
      end
      DM_DIVIDE: begin
        if (last_step) begin
          state_next = DM_DONE;
        end
      end
      DM_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = DM_IDLE;
        end
      end
      default: begin
        state_next = DM_IDLE;
      end
    endcase
  end

  // One restoring division step.
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    fits      = (rem_shift >= (CNT_W + 1)'(divisor));
    rem_next  = fits ? CNT_W'(rem_shift - (CNT_W + 1)'(divisor)) : CNT_W'(rem_shift);
  end

  // Magnitude of the incoming sum, and the signed, truncated result.
  assign sum_mag    = head.sum[SUM_W-1] ? SUM_W'(-head.sum) : SUM_W'(head.sum);
  assign quo_signed = neg ? SUM_W'(-quo) : quo;
  assign result     = (divisor == '0) ? '0
                    : DATA_W'(signed'(quo_signed[SAMPLE_BITS-1:0]));

  // Divider datapath.
  always_ff @(posedge clk) begin
    if (pop) begin
      quo     <= sum_mag;
      rem     <= '0;
      divisor <= head.count;
      neg     <= head.sum[SUM_W-1];
      step    <= '0;
    end else if (state == DM_DIVIDE) begin
      quo  <= {quo[SUM_W-2:0], fits};
      rem  <= rem_next;
      step <= step + STEP_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (mono_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

  assign mono_out.valid       = out_valid;
  assign mono_out.mono_sample = out_data;

  // A frame is taken only from a nonempty queue while the divider is free.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> (!qstat.empty && state == DM_IDLE))
    else $error("dm_back: pop from empty queue or while busy");

  // A frame with no nonzero samples carries a zero sum.
  assert property (@(posedge clk) disable iff (rst)
    (pop && head.count == '0) |-> (head.sum == '0))
    else $error("dm_back: zero count with nonzero sum");

  // The division ends after exactly one step per sum bit.
  assert property (@(posedge clk) disable iff (rst)
    (state == DM_DIVIDE && last_step) |=> (state == DM_DONE))
    else $error("dm_back: divider did not finish on the last step");

  // The output register is loaded only when it is free.
  assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("dm_back: result overwrote a waiting item");

endmodule

/* rtl/core/multichannel_to_mono_downmix_top.sv */
// ----------------------------------------------------------------------------
// multichannel_to_mono_downmix_top: multichannel to mono downmix
// Averages the nonzero samples of each interleaved frame into one mono item.
// ----------------------------------------------------------------------------
// Interleaved signed samples enter one item per cycle on sample_in, unless a
// frame-ending item waits for room in the queue. Each frame of channel_count
// items (0 counts as 1, values above 8 as 8) gives one item on mono_out: the
// exact frame sum divided by the number of nonzero samples, truncated toward
// zero, or 0 when all samples are zero. Items inside a frame are taken every
// cycle. The divider computes one quotient bit per cycle over the 36-bit sum:
// it loads, takes one step per sum bit, then hands off to the output register
// once free. A two-frame queue between accumulator and divider lets new frames
// accumulate during a division. channel_count is to be written through cfg_we
// and cfg_wdata only while idle, not enforced by the block; reset sets it to 2.
module multichannel_to_mono_downmix_top
  import dm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  dm_sample_if.sink        sample_in,
  dm_mono_if.source        mono_out
);

  dm_push_t  push;
  dm_frame_t head;
  dm_qstat_t qstat;
  logic      pop;

  // Accumulator side.
  dm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample_in (sample_in),
    .qstat     (qstat),
    .push      (push)
  );

  // Frame queue.
  dm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Divider side.
  dm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .mono_out (mono_out)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the multichannel to mono downmix block
// A short table of directed items covers the sample extremes, the all-zero
// frame and the channel count corner cases. Random phases follow, each with
// its own channel count and idling pattern. Every mono item the block returns
// is compared in order against a frame averager kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_top;
  import dm_pkg::*;

  localparam int DRAIN_CYCLES   = 120;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int DIRECTED_LEN   = 26;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [DATA_W-1:0] value;
    logic              known;
    logic [DATA_W-1:0] mono;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  dm_sample_if sample_if ();
  dm_mono_if   mono_if ();

  multichannel_to_mono_downmix_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample_in (sample_if),
    .mono_out  (mono_if)
  );

  // Frame averager state, mirrored from the block.
  logic [CFG_W-1:0]        channel_setting;
  logic [IDX_W-1:0]        frame_pos;
  logic signed [SUM_W-1:0] frame_total;
  logic [CNT_W-1:0]        nonzero_seen;
  logic                    zero_frame;

  logic [DATA_W-1:0] mono_expected [$];
  logic [DATA_W-1:0] mono_want;
  int                mismatch_count = 0;
  int                sender_idle_pct = 0;
  int                receiver_stall_pct = 0;

  // Directed items: the typed results can be read straight off each frame.
  stim_row_t directed_rows [DIRECTED_LEN] = '{
    '{ROW_SAMPLE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0005},
    '{ROW_SAMPLE, 32'hFFFF_FFF9, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0002, 1'b1, 32'hFFFF_FFFE},
    '{ROW_CONFIG, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_CONFIG, 32'h0000_000F, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_CONFIG, 32'h0000_0003, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0001, 1'b0, 32'h0},
    '{ROW_CONFIG, 32'h0000_0001, 1'b0, 32'h0},
    '{ROW_SAMPLE, 32'h0000_0002, 1'b1, 32'h0000_0001}
  };

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Adds one accepted sample to the frame and returns 1 when the frame closes.
  function automatic bit downmix_accept(input logic [DATA_W-1:0] raw,
                                        output logic [DATA_W-1:0] mono);
    logic signed [SAMPLE_BITS-1:0] value;
    logic signed [SUM_W-1:0]       quotient;
    int                            active;
    value = raw[SAMPLE_BITS-1:0];
    active = int'(channel_setting);
    if (active == 0) active = 1;
    if (active > MAX_CHANNELS) active = MAX_CHANNELS;
    frame_total = frame_total + SUM_W'(value);
    if (value != 0) nonzero_seen = nonzero_seen + 1'b1;
    mono = '0;
    if (int'(frame_pos) + 1 >= active) begin
      quotient = '0;
      if (nonzero_seen != 0) quotient = frame_total / $signed({1'b0, nonzero_seen});
      mono = quotient[DATA_W-1:0];
      frame_pos = '0;
      frame_total = '0;
      nonzero_seen = '0;
      return 1'b1;
    end
    frame_pos = frame_pos + 1'b1;
    return 1'b0;
  endfunction

  // Random samples: some frames are all zero, the rest mix zeros, extremes,
  // small values and full-range words.
  function automatic logic [DATA_W-1:0] next_random_sample();
    if (frame_pos == 0) zero_frame = ($urandom_range(7) == 0);
    if (zero_frame) return '0;
    case ($urandom_range(9))
      0, 1: return '0;
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      3, 4: return DATA_W'($urandom_range(200)) - DATA_W'(100);
      default: return $urandom;
    endcase
  endfunction

  // Sends one sample, with a random gap first, and records its result.
  task automatic push_sample(input logic [DATA_W-1:0] value, input logic known,
                             input logic [DATA_W-1:0] typed_mono);
    logic [DATA_W-1:0] mono;
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= value;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
    if (downmix_accept(value, mono)) mono_expected.push_back(known ? typed_mono : mono);
  endtask

  // Writes the channel count once the block has drained.
  task automatic write_channel_count(input logic [CFG_W-1:0] count);
    sample_if.valid <= 1'b0;
    while (mono_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    channel_setting = count;
  endtask

  // Mono receiver: ready follows the current stall rate.
  initial begin
    mono_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      mono_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Output checker: each mono item against the oldest expected one.
  always @(posedge clk) begin
    if (!rst && mono_if.valid && mono_if.ready) begin
      if (mono_expected.size() == 0) begin
        $display("%0t: unexpected mono_sample %h, none expected", $time,
                 mono_if.mono_sample);
        mismatch_count++;
      end else begin
        mono_want = mono_expected.pop_front();
        if (mono_if.mono_sample !== mono_want) begin
          $display("%0t: mono_sample mismatch, expected %h, got %h", $time,
                   mono_want, mono_if.mono_sample);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    logic [CFG_W-1:0] phase_count;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    sample_if.valid  <= 1'b0;
    sample_if.sample <= '0;
    channel_setting  = CFG_W'(2);
    frame_pos        = '0;
    frame_total      = '0;
    nonzero_seen     = '0;
    zero_frame       = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        write_channel_count(directed_rows[i].value[CFG_W-1:0]);
      end else begin
        push_sample(directed_rows[i].value, directed_rows[i].known, directed_rows[i].mono);
      end
    end

    // Each phase pairs a channel count with one idling pattern.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_count = CFG_W'(1);
        1: phase_count = CFG_W'(8);
        2: phase_count = CFG_W'(15);
        3: phase_count = CFG_W'(0);
        4: phase_count = CFG_W'($urandom_range(15));
        5: phase_count = CFG_W'(3);
        6: phase_count = CFG_W'($urandom_range(8, 1));
        default: phase_count = CFG_W'(2);
      endcase
      write_channel_count(phase_count);
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
        default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) push_sample(next_random_sample(), 1'b0, '0);
    end

    // Drain, then let any stray output show up.
    sample_if.valid <= 1'b0;
    while (mono_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
